>>> src/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg: shared types and constants
// Fixed-point formats, vector type and saturation helper for the vertex
// transform block.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VALUE_W   = 32;
  localparam int PROD_W    = 2 * VALUE_W;          // exact product
  localparam int PAIR_W    = PROD_W + 1;           // sum of two products
  localparam int SUM_W     = PROD_W + 2;           // sum of four products
  localparam int NUM_W     = VALUE_W + FRAC_BITS;  // dividend magnitude
  localparam int QUO_W     = VALUE_W + 1;          // quotient bits computed
  localparam int HEAD_W    = NUM_W - QUO_W;        // dividend bits above quotient

  typedef logic signed [VALUE_W-1:0] val_t;

  typedef struct packed {
    val_t x;
    val_t y;
    val_t z;
    val_t w;
  } vec_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_VERTEX = 1'b1
  } op_t;

  localparam val_t ONE     = val_t'(64'sd1 <<< FRAC_BITS);
  localparam val_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // floor(s / 2^FRAC_BITS), saturated to the value range
  function automatic val_t sat_sum(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    val_t res;
    sh = s >>> FRAC_BITS;
    if (sh > SUM_W'(VAL_MAX)) begin
      res = VAL_MAX;
    end else if (sh < SUM_W'(VAL_MIN)) begin
      res = VAL_MIN;
    end else begin
      res = sh[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> src/vertex_transform_perspective_divide_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_top: 4x4 vertex transform
// Matrix times homogeneous vertex in Q16.16 with optional divide by w.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item. A word
//   with in_op = load writes matrix entry in_entry_index (row*4+column) at
//   the accepting edge and yields no result; the next vertex already sees
//   it. A word with in_op = vertex is transformed and gives one result word.
//   cfg_we / cfg_wdata set perspective enable; write it only while idle.
// Pipeline: 38 register stages (multiply, two adder stages, divider set-up,
//   33 one-bit divide stages, output register).
// Throughput: one word per cycle unless stalled; the divide is pipelined one
//   quotient bit per stage, so every stage holds a separate vertex.
// Stall: each stage moves when it is empty or the next one moves, so bubbles
//   close up and words pile up behind a stalled output; in_stall rises only
//   once the pipe is full back to the multiplier.
// Reset: synchronous active-low rst_n empties the pipe, loads the identity
//   matrix and clears perspective enable.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_top
  import vtpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [3:0] in_entry_index,
  input  val_t       in_entry_value,
  input  val_t       in_x,
  input  val_t       in_y,
  input  val_t       in_z,
  input  val_t       in_w,
  output logic       out_valid,
  input  logic       out_stall,
  output val_t       out_x,
  output val_t       out_y,
  output val_t       out_z,
  output val_t       out_w,
  output logic       out_divided
);

  logic persp_r;
  val_t mat_r [16];

  // stage enables: a stage loads when empty or when its successor loads
  logic en_p, en_a, en_b, div_stall;
  logic p_v_r, a_v_r, b_v_r;

  logic signed [PROD_W-1:0] prod_r [4][4];
  logic signed [PAIR_W-1:0] pair_r [4][2];
  vec_t                     res_r;

  val_t vin [4];
  logic accept;

  assign en_b     = !b_v_r || !div_stall;
  assign en_a     = !a_v_r || en_b;
  assign en_p     = !p_v_r || en_a;
  assign in_stall = !en_p;
  assign accept   = in_valid && en_p;

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;
  assign vin[3] = in_w;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persp_r <= 1'b0;
    end else if (cfg_we) begin
      persp_r <= cfg_wdata;
    end
  end

  // matrix: identity at reset, one entry per load word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= ((i >> 2) == (i & 3)) ? ONE : '0;
      end
    end else if (accept && (in_op == OP_LOAD)) begin
      mat_r[in_entry_index] <= in_entry_value;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (en_p) p_v_r <= in_valid && (in_op == OP_VERTEX);
      if (en_a) a_v_r <= p_v_r;
      if (en_b) b_v_r <= a_v_r;
    end
  end

  // stage P: sixteen exact products
  always_ff @(posedge clk) begin
    if (en_p) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r][c] <= mat_r[r*4 + c] * vin[c];
        end
      end
    end
  end

  // stage A: pairwise sums
  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int r = 0; r < 4; r++) begin
        pair_r[r][0] <= PAIR_W'(prod_r[r][0]) + PAIR_W'(prod_r[r][1]);
        pair_r[r][1] <= PAIR_W'(prod_r[r][2]) + PAIR_W'(prod_r[r][3]);
      end
    end
  end

  // stage B: row sum, floor shift and saturate
  always_ff @(posedge clk) begin
    if (en_b) begin
      res_r.x <= sat_sum(SUM_W'(pair_r[0][0]) + SUM_W'(pair_r[0][1]));
      res_r.y <= sat_sum(SUM_W'(pair_r[1][0]) + SUM_W'(pair_r[1][1]));
      res_r.z <= sat_sum(SUM_W'(pair_r[2][0]) + SUM_W'(pair_r[2][1]));
      res_r.w <= sat_sum(SUM_W'(pair_r[3][0]) + SUM_W'(pair_r[3][1]));
    end
  end

  vec_t out_res;

  vtpd_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .persp_en   (persp_r),
    .in_valid   (b_v_r),
    .in_stall   (div_stall),
    .in_res     (res_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .out_divided(out_divided)
  );

  assign out_x = out_res.x;
  assign out_y = out_res.y;
  assign out_z = out_res.z;
  assign out_w = out_res.w;

endmodule

>>> src/vtpd_divider.sv
// ----------------------------------------------------------------------------
// vtpd_divider: pipelined perspective divide
// Restoring division, one quotient bit per stage for x, y and z in parallel;
// words that need no divide ride along unchanged.
// ----------------------------------------------------------------------------
module vtpd_divider
  import vtpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic persp_en,
  input  logic in_valid,
  output logic in_stall,
  input  vec_t in_res,
  output logic out_valid,
  input  logic out_stall,
  output vec_t out_res,
  output logic out_divided
);

  localparam int LAST = QUO_W;

  logic [LAST:0]      v_r;
  logic [LAST+1:0]    en;
  vec_t               vec_r  [LAST+1];
  logic               dd_r   [LAST+1];
  logic [VALUE_W-1:0] d_r    [LAST+1];
  logic [NUM_W-1:0]   n_r    [LAST+1][3];
  logic [QUO_W-1:0]   rem_r  [LAST+1][3];
  logic [QUO_W-1:0]   q_r    [LAST+1][3];
  logic               neg_r  [LAST+1][3];
  logic               ovf_r  [LAST+1][3];

  logic out_v_r;
  vec_t out_res_r;
  logic out_div_r;

  assign en[LAST+1] = !out_v_r || !out_stall;
  assign en[0]      = !v_r[0] || en[1];
  assign in_stall   = !en[0];

  // stage 0: decide, take magnitudes, flag quotient overflow
  val_t               lane_in [3];
  logic [NUM_W-1:0]   num_s   [3];
  logic [NUM_W-1:0]   nmag    [3];
  logic [VALUE_W-1:0] dmag;
  logic               do_div;

  always_comb begin
    lane_in[0] = in_res.x;
    lane_in[1] = in_res.y;
    lane_in[2] = in_res.z;
    do_div = persp_en && (in_res.w != '0) && (in_res.w != ONE);
    dmag   = in_res.w[VALUE_W-1] ? VALUE_W'(-in_res.w) : in_res.w;
    for (int i = 0; i < 3; i++) begin
      num_s[i] = {lane_in[i], {FRAC_BITS{1'b0}}};
      nmag[i]  = lane_in[i][VALUE_W-1] ? (NUM_W'(0) - num_s[i]) : num_s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vec_r[0] <= in_res;
      dd_r[0]  <= do_div;
      d_r[0]   <= dmag;
      for (int i = 0; i < 3; i++) begin
        n_r[0][i]   <= nmag[i];
        rem_r[0][i] <= QUO_W'(nmag[i][NUM_W-1:QUO_W]);
        q_r[0][i]   <= '0;
        neg_r[0][i] <= lane_in[i][VALUE_W-1] ^ in_res.w[VALUE_W-1];
        ovf_r[0][i] <= VALUE_W'(nmag[i][NUM_W-1:QUO_W]) >= dmag;
      end
    end
  end

  // stages 1..LAST: one quotient bit each, most significant first
  for (genvar s = 1; s <= LAST; s++) begin : g_stage
    localparam int BIT = LAST - s;
    logic [QUO_W:0] trial [3];
    logic           take  [3];

    assign en[s] = !v_r[s] || en[s+1];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem_r[s-1][i], n_r[s-1][i][BIT]};
        take[i]  = trial[i] >= (QUO_W+1)'(d_r[s-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        vec_r[s] <= vec_r[s-1];
        dd_r[s]  <= dd_r[s-1];
        d_r[s]   <= d_r[s-1];
        for (int i = 0; i < 3; i++) begin
          n_r[s][i]   <= n_r[s-1][i];
          neg_r[s][i] <= neg_r[s-1][i];
          ovf_r[s][i] <= ovf_r[s-1][i];
          q_r[s][i]   <= {q_r[s-1][i][QUO_W-2:0], take[i]};
          if (take[i]) begin
            rem_r[s][i] <= QUO_W'(trial[i] - (QUO_W+1)'(d_r[s-1]));
          end else begin
            rem_r[s][i] <= trial[i][QUO_W-1:0];
          end
        end
      end
    end
  end

  // output: apply sign and saturate the quotient
  val_t lane_out [3];
  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (VALUE_W - 1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (neg_r[LAST][i]) begin
        if (ovf_r[LAST][i] || (q_r[LAST][i] > NEG_LIM)) begin
          lane_out[i] = VAL_MIN;
        end else begin
          lane_out[i] = VALUE_W'(QUO_W'(0) - q_r[LAST][i]);
        end
      end else begin
        if (ovf_r[LAST][i] || (q_r[LAST][i] >= NEG_LIM)) begin
          lane_out[i] = VAL_MAX;
        end else begin
          lane_out[i] = q_r[LAST][i][VALUE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en[LAST+1]) begin
      out_v_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST+1]) begin
      out_div_r <= dd_r[LAST];
      if (dd_r[LAST]) begin
        out_res_r <= '{x: lane_out[0], y: lane_out[1], z: lane_out[2], w: ONE};
      end else begin
        out_res_r <= vec_r[LAST];
      end
    end
  end

  assign out_valid   = out_v_r;
  assign out_res     = out_res_r;
  assign out_divided = out_div_r;

endmodule

>>> src/vtpd_checker.sv
// ----------------------------------------------------------------------------
// vtpd_checker: port-level checks
// Watches the result channel of the vertex transform top level.
// ----------------------------------------------------------------------------
module vtpd_checker
  import vtpd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input val_t out_x,
  input val_t out_w,
  input logic out_divided
);

  a_rst_empty: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("result word present right after reset");

  a_div_w_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divided) |-> (out_w == ONE))
    else $error("divided word without w of one");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled word dropped");

  a_hold_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_x) && $stable(out_divided)))
    else $error("stalled word changed");

endmodule

bind vertex_transform_perspective_divide_top vtpd_checker u_vtpd_checker (.*);
